>>> hw/rtl/fcq_pkg.sv
package fcq_pkg;

    localparam int LANES    = 4;
    localparam int SAT_BITS = 8;

    localparam int DATA_W   = 16;
    localparam int ACC_W    = 32;
    localparam int SHIFT_W  = 5;
    localparam int OUT_W    = 8;
    localparam int CNT_W    = 3;

    // result queue; four entries cover the accept-to-output span at full rate
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((2 ** (SAT_BITS - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    localparam logic [CNT_W-1:0] LANE_CNT_MAX = CNT_W'(LANES);

    // register indexes on the config port
    localparam logic REG_BIAS_LSHIFT  = 1'b0;
    localparam logic REG_RESULT_SHIFT = 1'b1;

    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last;
        logic [CNT_W-1:0] count;
    } t_ctrl;

endpackage

>>> hw/rtl/fcq_lane.sv
module fcq_lane
    import fcq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  logic signed [DATA_W-1:0] i_activation,
    input  logic signed [DATA_W-1:0] i_weight,
    input  logic signed [DATA_W-1:0] i_bias,
    input  logic [SHIFT_W-1:0]       i_bias_lshift,
    input  logic [SHIFT_W-1:0]       i_result_shift,
    input  t_ctrl                    i_a,
    output logic signed [OUT_W-1:0]  o_result
);

    logic signed [ACC_W-1:0] r_prod;
    logic signed [ACC_W-1:0] r_bias;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] n_acc;
    logic signed [ACC_W-1:0] acc_sh;
    logic signed [ACC_W-1:0] sat_val;

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_prod <= ACC_W'(i_activation) * ACC_W'(i_weight);
            r_bias <= {{(ACC_W - DATA_W){i_bias[DATA_W-1]}}, i_bias} << i_bias_lshift;
        end
    end

    // a group start replaces the running sum with the shifted bias
    assign n_acc = (i_a.first ? r_bias : r_acc) + r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_a.valid) begin
            r_acc <= n_acc;
        end
    end

    assign acc_sh = r_acc >>> i_result_shift;

    always_comb begin
        if (acc_sh > SAT_HI) begin
            sat_val = SAT_HI;
        end else if (acc_sh < SAT_LO) begin
            sat_val = SAT_LO;
        end else begin
            sat_val = acc_sh;
        end
    end

    assign o_result = sat_val[OUT_W-1:0];

endmodule

>>> hw/rtl/fcq_merge.sv
module fcq_merge
    import fcq_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_reserve,
    input  logic                   i_wr,
    input  logic [CNT_W-1:0]       i_count,
    input  logic [LANES*OUT_W-1:0] i_lane_res,
    input  logic                   i_take,
    output logic                   o_ready,
    output logic                   o_valid,
    output logic [LANES*OUT_W-1:0] o_data,
    output logic [CNT_W-1:0]       o_user
);

    typedef struct packed {
        logic [CNT_W-1:0]       count;
        logic [LANES*OUT_W-1:0] data;
    } t_entry;

    t_entry               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr;
    logic [FIFO_AW-1:0]   r_rd_ptr;
    logic [FIFO_CW-1:0]   r_fill;
    logic [FIFO_CW-1:0]   r_used;
    logic [FIFO_CW-1:0]   n_fill;
    logic [FIFO_CW-1:0]   n_used;
    t_entry               wr_entry;

    // lanes past the group's row count read as zero
    always_comb begin
        wr_entry.count = i_count;
        for (int k = 0; k < LANES; k++) begin
            if (CNT_W'(k) < i_count) begin
                wr_entry.data[k*OUT_W +: OUT_W] = i_lane_res[k*OUT_W +: OUT_W];
            end else begin
                wr_entry.data[k*OUT_W +: OUT_W] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= wr_entry;
        end
    end

    // r_used counts slots claimed at input accept, so pipeline results always fit
    assign n_fill = r_fill + FIFO_CW'(i_wr) - FIFO_CW'(i_take);
    assign n_used = r_used + FIFO_CW'(i_reserve) - FIFO_CW'(i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
            r_used   <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (i_take) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            r_fill <= n_fill;
            r_used <= n_used;
        end
    end

    assign o_ready = (r_used < FIFO_CW'(FIFO_DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_data  = r_mem[r_rd_ptr].data;
    assign o_user  = r_mem[r_rd_ptr].count;

`ifndef SYNTH
    a_fill_le_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_used)
        else $error("queue holds more beats than were reserved");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> (r_fill < FIFO_CW'(FIFO_DEPTH)))
        else $error("result written into a full queue");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= FIFO_CW'(FIFO_DEPTH))
        else $error("reservation count beyond queue depth");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_user != '0 && o_user <= LANE_CNT_MAX))
        else $error("output lane count out of range");
`endif

endmodule

>>> hw/rtl/fc_layer_q15_mac_four_rows.sv
// Fully connected layer, Q15, four output rows per group.
// Input stream (s_axis): one beat per vector element; tdata carries the
// activation, four weights and four biases; tuser[0] marks group start,
// tuser[3:1] the group's row count (0 taken as 1, above 4 taken as 4);
// tlast marks the last element and produces one result beat.
// Output stream (m_axis): four saturated 8-bit row results in tdata,
// row count in tuser; lanes at or past the count read zero.
// Throughput: one input beat per cycle while input ready is high. Each lane
// has its own 16x16 multiplier and 32-bit accumulator, so one element per
// cycle is set by the registered multiply feeding the accumulate add.
// A group's last element is registered as product, then sum, then queue entry.
// Results wait in a four-entry queue; input ready drops once four results
// are queued or in flight, and then every input beat waits for the receiver.
// Reset: accumulators zero, row count four, shift registers zero, queue empty.
// Config (APB, 0x0 bias shift, 0x4 result shift) is to be written by the user
// only while idle; the block itself does not enforce this.
module fc_layer_q15_mac_four_rows
    import fcq_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,

    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // activation, weight_lane0..3, bias_lane0..3 (16 bits each, from bit 0 up)
    input  logic [143:0] s_axis_tdata,
    // group_start [0], lanes_active [3:1]
    input  logic [3:0]   s_axis_tuser,
    input  logic         s_axis_tlast,

    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_lane0..3 (8 bits each, from bit 0 up)
    output logic [31:0]  m_axis_tdata,
    // lanes_valid [2:0]
    output logic [2:0]   m_axis_tuser,

    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [SHIFT_W-1:0]     r_bias_lshift;
    logic [SHIFT_W-1:0]     r_result_shift;
    logic [CNT_W-1:0]       r_group_cnt;
    logic [CNT_W-1:0]       n_group_cnt;
    logic [CNT_W-1:0]       lanes_req;
    t_ctrl                  r_a;
    t_ctrl                  r_b;
    logic                   accept;
    logic                   take;
    logic                   cfg_wr;
    logic [LANES*OUT_W-1:0] lane_res;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias_lshift  <= '0;
            r_result_shift <= '0;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_BIAS_LSHIFT:  r_bias_lshift  <= pwdata[SHIFT_W-1:0];
                REG_RESULT_SHIFT: r_result_shift <= pwdata[SHIFT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_BIAS_LSHIFT:  prdata = {{(32 - SHIFT_W){1'b0}}, r_bias_lshift};
            REG_RESULT_SHIFT: prdata = {{(32 - SHIFT_W){1'b0}}, r_result_shift};
            default:          prdata = '0;
        endcase
    end

    assign accept = s_axis_tvalid & s_axis_tready;
    assign take   = m_axis_tvalid & m_axis_tready;

    assign lanes_req = s_axis_tuser[3:1];

    always_comb begin
        if (!s_axis_tuser[0]) begin
            n_group_cnt = r_group_cnt;
        end else if (lanes_req == '0) begin
            n_group_cnt = CNT_W'(1);
        end else if (lanes_req > LANE_CNT_MAX) begin
            n_group_cnt = LANE_CNT_MAX;
        end else begin
            n_group_cnt = lanes_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_cnt <= LANE_CNT_MAX;
            r_a         <= '0;
            r_b         <= '0;
        end else begin
            if (accept) begin
                r_group_cnt <= n_group_cnt;
            end
            r_a.valid <= accept;
            r_a.first <= s_axis_tuser[0];
            r_a.last  <= s_axis_tlast;
            r_a.count <= n_group_cnt;
            r_b       <= r_a;
        end
    end

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        fcq_lane u_lane (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_accept       (accept),
            .i_activation   (s_axis_tdata[DATA_W-1:0]),
            .i_weight       (s_axis_tdata[(1 + k)*DATA_W +: DATA_W]),
            .i_bias         (s_axis_tdata[(1 + LANES + k)*DATA_W +: DATA_W]),
            .i_bias_lshift  (r_bias_lshift),
            .i_result_shift (r_result_shift),
            .i_a            (r_a),
            .o_result       (lane_res[k*OUT_W +: OUT_W])
        );
    end

    fcq_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_reserve  (accept & s_axis_tlast),
        .i_wr       (r_b.valid & r_b.last),
        .i_count    (r_b.count),
        .i_lane_res (lane_res),
        .i_take     (take),
        .o_ready    (s_axis_tready),
        .o_valid    (m_axis_tvalid),
        .o_data     (m_axis_tdata),
        .o_user     (m_axis_tuser)
    );

endmodule

>>> tb/fcq_checker.sv
module fcq_checker
    import fcq_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,

    input  logic         i_in_valid,
    input  logic         i_in_ready,
    // activation, weight_lane0..3, bias_lane0..3 (16 bits each, from bit 0 up)
    input  logic [143:0] i_in_data,
    // group_start [0], lanes_active [3:1]
    input  logic [3:0]   i_in_user,
    input  logic         i_in_last,

    input  logic         i_out_valid,
    input  logic         i_out_ready,
    // out_lane0..3 (8 bits each, from bit 0 up)
    input  logic [31:0]  i_out_data,
    // lanes_valid [2:0]
    input  logic [2:0]   i_out_user,

    input  logic         i_psel,
    input  logic         i_penable,
    input  logic         i_pwrite,
    input  logic [2:0]   i_paddr,
    input  logic [31:0]  i_pwdata,
    input  logic [31:0]  i_prdata,
    input  logic         i_pready,

    output int           o_fail_count,
    output int           o_pending,
    output int           o_results
);

    typedef struct packed {
        logic [CNT_W-1:0]            rows;
        logic [LANES-1:0][OUT_W-1:0] lane;
    } t_row_result;

    localparam int SAT_MAX = 2 ** (SAT_BITS - 1) - 1;
    localparam int SAT_MIN = -SAT_MAX - 1;

    logic [ACC_W-1:0]   lane_sum [LANES];
    logic [CNT_W-1:0]   row_count;
    logic [SHIFT_W-1:0] bias_lshift;
    logic [SHIFT_W-1:0] result_shift;
    t_row_result        rows_expected_q [$];
    int                 mismatches = 0;
    int                 compared   = 0;

    function automatic logic [OUT_W-1:0] saturate_row(input logic [ACC_W-1:0] sum,
                                                      input logic [SHIFT_W-1:0] sh);
        logic signed [ACC_W-1:0] v;
        v = $signed(sum) >>> sh;
        if (v > SAT_MAX) begin
            v = SAT_MAX;
        end else if (v < SAT_MIN) begin
            v = SAT_MIN;
        end
        return v[OUT_W-1:0];
    endfunction

    always @(posedge i_clk) begin : monitor
        t_row_result              want;
        t_row_result              got;
        logic signed [DATA_W-1:0] act;
        logic signed [DATA_W-1:0] bias;
        logic signed [ACC_W-1:0]  prod;
        logic [CNT_W-1:0]         n;
        logic [SHIFT_W-1:0]       reg_val;
        int                       k;

        if (!i_rst_n) begin
            for (k = 0; k < LANES; k++) begin
                lane_sum[k] = '0;
            end
            row_count    = LANE_CNT_MAX;
            bias_lshift  = '0;
            result_shift = '0;
            rows_expected_q.delete();
        end else begin
            if (i_psel && i_penable && i_pready) begin
                reg_val = (i_paddr[2] == REG_BIAS_LSHIFT) ? bias_lshift : result_shift;
                if (i_pwrite) begin
                    if (i_paddr[2] == REG_BIAS_LSHIFT) begin
                        bias_lshift = i_pwdata[SHIFT_W-1:0];
                    end else begin
                        result_shift = i_pwdata[SHIFT_W-1:0];
                    end
                end else if (i_prdata !== 32'(reg_val)) begin
                    $error("prdata: expected %0d, got %0d", reg_val, i_prdata);
                    mismatches++;
                end
            end

            // result beats trail their input beat through registers, so pop first
            if (i_out_valid && i_out_ready) begin
                got = {i_out_user, i_out_data};
                compared++;
                if (rows_expected_q.size() == 0) begin
                    $error("lanes_valid: expected no beat, got %0d", got.rows);
                    mismatches++;
                end else begin
                    want = rows_expected_q.pop_front();
                    if (got.rows !== want.rows) begin
                        $error("lanes_valid: expected %0d, got %0d", want.rows, got.rows);
                        mismatches++;
                    end
                    for (k = 0; k < LANES; k++) begin
                        if (got.lane[k] !== want.lane[k]) begin
                            $error("out_lane%0d: expected %0d, got %0d", k,
                                   $signed(want.lane[k]), $signed(got.lane[k]));
                            mismatches++;
                        end
                    end
                end
            end

            if (i_in_valid && i_in_ready) begin
                act = i_in_data[DATA_W-1:0];
                if (i_in_user[0]) begin
                    n = i_in_user[CNT_W:1];
                    if (n == '0) begin
                        n = CNT_W'(1);
                    end else if (n > LANE_CNT_MAX) begin
                        n = LANE_CNT_MAX;
                    end
                    row_count = n;
                    for (k = 0; k < LANES; k++) begin
                        bias = i_in_data[DATA_W*(1+LANES+k) +: DATA_W];
                        lane_sum[k] = {{(ACC_W-DATA_W){bias[DATA_W-1]}}, bias} << bias_lshift;
                    end
                end
                // every lane accumulates, active or not
                for (k = 0; k < LANES; k++) begin
                    prod = act * $signed(i_in_data[DATA_W*(1+k) +: DATA_W]);
                    lane_sum[k] = lane_sum[k] + prod;
                end
                if (i_in_last) begin
                    want.rows = row_count;
                    for (k = 0; k < LANES; k++) begin
                        want.lane[k] = (k < row_count) ?
                                       saturate_row(lane_sum[k], result_shift) : '0;
                    end
                    rows_expected_q.push_back(want);
                end
            end
        end

        o_fail_count <= mismatches;
        o_pending    <= rows_expected_q.size();
        o_results    <= compared;
    end

endmodule

>>> tb/tb_fc_layer_q15_mac_four_rows.sv
module tb_fc_layer_q15_mac_four_rows;
    import fcq_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_STALL     = 600;
    localparam int STALL_AT       = 400;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_BEATS    = 250;
    localparam int SETTLE         = 8;

    typedef struct packed {
        logic [CNT_W-1:0]             lanes;
        logic                         last;
        logic                         start;
        logic [LANES-1:0][DATA_W-1:0] bias;
        logic [LANES-1:0][DATA_W-1:0] weight;
        logic [DATA_W-1:0]            act;
    } t_fc_beat;

    logic         i_clk   = 1'b0;
    logic         i_rst_n = 1'b0;

    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // activation, weight_lane0..3, bias_lane0..3 (16 bits each, from bit 0 up)
    logic [143:0] s_axis_tdata  = '0;
    // group_start [0], lanes_active [3:1]
    logic [3:0]   s_axis_tuser  = '0;
    logic         s_axis_tlast  = 1'b0;

    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // out_lane0..3 (8 bits each, from bit 0 up)
    logic [31:0]  m_axis_tdata;
    // lanes_valid [2:0]
    logic [2:0]   m_axis_tuser;

    logic         psel    = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite  = 1'b0;
    logic [2:0]   paddr   = '0;
    logic [31:0]  pwdata  = '0;
    logic [31:0]  prdata;
    logic         pready;

    int fail_count;
    int pending;
    int results;
    int beats_sent  = 0;
    int settings    = 0;
    int idle_cycles = 0;
    int tx_gap_pct  = 0;
    bit calm        = 1'b0;

    fc_layer_q15_mac_four_rows uut (.*);

    fcq_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_user    (s_axis_tuser),
        .i_in_last    (s_axis_tlast),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_user   (m_axis_tuser),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("fc_layer_q15_mac_four_rows: mismatch");
            $finish;
        end
    end

    function automatic logic [DATA_W-1:0] rand_q15();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'($urandom_range(0, 16) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_fc_beat mk_beat(input logic [DATA_W-1:0] act, w0, w1, b0, b1,
                                         input logic st, lst, input logic [CNT_W-1:0] lanes);
        t_fc_beat bt;
        bt.act    = act;
        bt.weight = {w1, w0, w1, w0};
        bt.bias   = {b1, b0, b1, b0};
        bt.start  = st;
        bt.last   = lst;
        bt.lanes  = lanes;
        return bt;
    endfunction

    task automatic send_beat(input t_fc_beat bt);
        if (!calm && $urandom_range(0, 99) < tx_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {bt.bias, bt.weight, bt.act};
        s_axis_tuser  <= {bt.lanes, bt.start};
        s_axis_tlast  <= bt.last;
        do @(posedge i_clk); while (!s_axis_tready);
        beats_sent++;
    endtask

    // broken runs put start and end marks at random
    task automatic send_group(input int len, input bit broken);
        t_fc_beat bt;
        int       i;
        int       j;
        case ($urandom_range(0, 2))
            0:       tx_gap_pct = 0;
            1:       tx_gap_pct = 10;
            default: tx_gap_pct = 40;
        endcase
        for (i = 0; i < len; i++) begin
            bt.act = rand_q15();
            for (j = 0; j < LANES; j++) begin
                bt.weight[j] = rand_q15();
                bt.bias[j]   = rand_q15();
            end
            bt.lanes = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(1, 4))
                                                  : 3'($urandom_range(0, 7));
            bt.start = broken ? ($urandom_range(0, 3) == 0) : (i == 0);
            bt.last  = broken ? ($urandom_range(0, 3) == 0) : (i == len - 1);
            send_beat(bt);
        end
    endtask

    task automatic apb_xfer(input logic wr, input logic idx, input logic [SHIFT_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    // write and read back both shifts once the block has gone quiet
    task automatic set_shifts(input logic [SHIFT_W-1:0] bias_sh,
                              input logic [SHIFT_W-1:0] res_sh);
        s_axis_tvalid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        apb_xfer(1'b1, REG_BIAS_LSHIFT, bias_sh);
        apb_xfer(1'b0, REG_BIAS_LSHIFT, '0);
        apb_xfer(1'b1, REG_RESULT_SHIFT, res_sh);
        apb_xfer(1'b0, REG_RESULT_SHIFT, '0);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        settings++;
    endtask

    initial begin : sink
        bit stall_done;
        int rx_left;
        int rx_pct;
        stall_done = 1'b0;
        rx_left    = 0;
        rx_pct     = 0;
        @(posedge i_clk);
        forever begin
            if (rx_left == 0) begin
                rx_left = $urandom_range(50, 300);
                case ($urandom_range(0, 2))
                    0:       rx_pct = 0;
                    1:       rx_pct = 15;
                    default: rx_pct = 40;
                endcase
            end
            rx_left--;
            if (!stall_done && beats_sent >= STALL_AT) begin
                // long hold-off: results pile up and the input backs up
                m_axis_tready <= 1'b0;
                repeat (LONG_STALL) @(posedge i_clk);
                stall_done = 1'b1;
            end else if (!calm && $urandom_range(0, 99) < rx_pct) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        int               p;
        int               start_count;
        int               len;
        logic [SHIFT_W-1:0] bsh;
        logic [SHIFT_W-1:0] rsh;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        tx_gap_pct = 20;

        // end with no start: sums and row count straight from reset
        send_beat(mk_beat(16'h0003, 16'h0005, 16'hfffe, 16'h0000, 16'h0000, 1'b0, 1'b1, 3'd4));
        // single-beat groups; zero rows reads as one, above four clamps
        send_beat(mk_beat(16'h0064, 16'h0001, 16'hffff, 16'h0005, 16'hfffb, 1'b1, 1'b1, 3'd0));
        send_beat(mk_beat(16'h0002, 16'h0010, 16'hfff0, 16'h0007, 16'hfff9, 1'b1, 1'b1, 3'd5));
        send_beat(mk_beat(16'h0002, 16'h0010, 16'hfff0, 16'h0007, 16'hfff9, 1'b1, 1'b1, 3'd6));
        send_beat(mk_beat(16'h0002, 16'h0010, 16'hfff0, 16'h0007, 16'hfff9, 1'b1, 1'b1, 3'd7));
        // just past both saturation limits
        send_beat(mk_beat(16'h0001, 16'h007f, 16'hff80, 16'h0001, 16'hffff, 1'b1, 1'b1, 3'd4));
        // three max products wrap the 32-bit sum
        send_beat(mk_beat(16'h8000, 16'h8000, 16'h7fff, 16'h0000, 16'h0000, 1'b1, 1'b0, 3'd2));
        send_beat(mk_beat(16'h8000, 16'h8000, 16'h7fff, 16'h0000, 16'h0000, 1'b0, 1'b0, 3'd2));
        send_beat(mk_beat(16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0000, 1'b0, 1'b1, 3'd2));
        send_beat(mk_beat(16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 1'b1, 1'b0, 3'd3));
        send_beat(mk_beat(16'h7fff, 16'h8000, 16'h7fff, 16'h0000, 16'h0000, 1'b0, 1'b1, 3'd3));
        send_beat(mk_beat(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1, 3'd4));
        // end with no start again: carries the previous sums on
        send_beat(mk_beat(16'h0001, 16'h0001, 16'h0001, 16'h0000, 16'h0000, 1'b0, 1'b1, 3'd4));

        // widest bias shift, widest result shift
        set_shifts(5'd16, 5'd31);
        send_beat(mk_beat(16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h7fff, 1'b1, 1'b1, 3'd4));
        send_beat(mk_beat(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1, 1'b1, 3'd4));

        // mid-range shifts, with sums that still saturate every lane
        set_shifts(5'd8, 5'd9);
        send_beat(mk_beat(16'h00c8, 16'h012c, 16'hfed4, 16'h0064, 16'hff9c, 1'b1, 1'b0, 3'd4));
        send_beat(mk_beat(16'hfc18, 16'h0007, 16'h0009, 16'h0000, 16'h0000, 1'b0, 1'b0, 3'd4));
        send_beat(mk_beat(16'h0321, 16'h0055, 16'hffab, 16'h0000, 16'h0000, 1'b0, 1'b1, 3'd4));

        for (p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin bsh = 5'd16; rsh = 5'd31; end
                1: begin bsh = 5'd0;  rsh = 5'd0;  end
                2: begin bsh = 5'd16; rsh = 5'd0;  end
                3: begin bsh = 5'd0;  rsh = 5'd31; end
                default: begin
                    bsh = 5'($urandom_range(0, 16));
                    rsh = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                      : 5'($urandom_range(20, 31));
                end
            endcase
            calm = (p == RANDOM_PHASES - 1);
            set_shifts(bsh, rsh);
            start_count = beats_sent;
            while (beats_sent - start_count < PHASE_BEATS) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
                send_group(len, $urandom_range(0, 9) == 0);
            end
            // close whatever a broken run left open
            send_group(1, 1'b0);
        end

        s_axis_tvalid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("run covered %0d input beats and %0d row results over %0d shift settings,",
                 beats_sent, results, settings);
        $display("with random gaps on both streams and one %0d-cycle output hold-off",
                 LONG_STALL);
        if (fail_count == 0 && pending == 0) begin
            $display("fc_layer_q15_mac_four_rows: match");
        end else begin
            $display("fc_layer_q15_mac_four_rows: mismatch");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/fcq_pkg.sv
hw/rtl/fcq_lane.sv
hw/rtl/fcq_merge.sv
hw/rtl/fc_layer_q15_mac_four_rows.sv
tb/fcq_checker.sv
tb/tb_fc_layer_q15_mac_four_rows.sv
